// ===== src/lrut_pkg.sv =====
// lrut_pkg: command and status codes and fixed stream widths for the lru replacement tracker
// no dependencies; imported by lru_replacement_tracker
package lrut_pkg;

    // request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_VICTIM = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // result status carried on the master tuser
    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    localparam int KEY_PORT_W  = 32;
    localparam int COUNT_W     = 5;
    localparam int OUT_DATA_W  = 40;

endpackage

// ===== src/lrut_ram.sv =====
// lrut_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies; used by lru_replacement_tracker for the slot table
module lrut_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/lru_replacement_tracker.sv =====
// lru_replacement_tracker: recency-ordered set of up to CAPACITY keys (insert, victim, erase)
// depends on lrut_pkg and lrut_ram
//
// One request at a time. Each slot holds a key and a recency rank (0 is most recent) in one
// ram word; valid bits and the key count sit in flops. A request is served by a small
// sequencer that walks the slot ram through its single read port: a find pass locates the
// key (or the least recent slot, or the lowest free slot), and an update pass rewrites the
// ranks through the write port. An insert with a free slot and a hit run both passes; a
// miss or a full reject skips the update pass, and a victim on an empty set or an unused
// command skips both. The key is reduced to KEY_BITS bits (at most 32 are kept) before use.
module lru_replacement_tracker
    import lrut_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [KEY_PORT_W-1:0] i_s_tdata,   // [31:0] key
    input  logic [1:0]            i_s_tuser,   // [1:0] cmd
    // result channel
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] victim_key, [36:32] count, rest zero
    output logic [1:0]            o_m_tuser    // [1:0] status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int RAM_W = KW + AW;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FIND   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_issue, n_issue;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pidx, n_pidx;
    t_cmd                r_cmd, n_cmd;
    logic [KW-1:0]       r_key, n_key;
    logic                r_hit, n_hit;
    logic [AW-1:0]       r_slot, n_slot;
    logic [AW-1:0]       r_rank, n_rank;
    logic [KW-1:0]       r_vkey, n_vkey;
    logic                r_free_hit, n_free_hit;
    logic [AW-1:0]       r_free, n_free;
    t_status             r_status, n_status;
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_vld, n_out_vld;
    t_status             r_out_status, n_out_status;
    logic [KEY_PORT_W-1:0] r_out_vkey, n_out_vkey;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [RAM_W-1:0]    ram_rd_data;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [RAM_W-1:0]    ram_wr_data;

    logic                scan_go;
    logic                scan_end;
    logic [KW-1:0]       rd_key;
    logic [AW-1:0]       rd_rank;
    logic                rd_vld;
    logic                hit_now;
    logic                is_slot;

    // slot table: key above rank
    lrut_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign rd_key   = ram_rd_data[AW +: KW];
    assign rd_rank  = ram_rd_data[AW-1:0];
    assign rd_vld   = r_valid[r_pidx];
    assign scan_go  = (r_issue != CAP_C);
    assign scan_end = !scan_go && !r_pend;
    assign is_slot  = (r_pidx == r_slot);
    assign hit_now  = (r_cmd == CMD_VICTIM)
                    ? (rd_vld && (rd_rank == AW'(r_count - 1'b1)))
                    : (rd_vld && (rd_key == r_key));

    // sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_hit        = r_hit;
        n_slot       = r_slot;
        n_rank       = r_rank;
        n_vkey       = r_vkey;
        n_free_hit   = r_free_hit;
        n_free       = r_free;
        n_status     = r_status;
        n_valid      = r_valid;
        n_count      = r_count;
        n_out_vld    = r_out_vld;
        n_out_status = r_out_status;
        n_out_vkey   = r_out_vkey;
        n_out_count  = r_out_count;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_issue[AW-1:0];
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_pidx;
        ram_wr_data  = {rd_key, rd_rank};

        // result taken downstream
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        // slot walk shared by both passes
        if (r_state == S_FIND || r_state == S_UPDATE) begin
            ram_rd_en = scan_go;
            n_pend    = scan_go;
            n_pidx    = r_issue[AW-1:0];
            if (scan_go) begin
                n_issue = r_issue + 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd      = t_cmd'(i_s_tuser);
                    n_key      = i_s_tdata[KW-1:0];
                    n_hit      = 1'b0;
                    n_free_hit = 1'b0;
                    n_issue    = '0;
                    n_pend     = 1'b0;
                    n_vkey     = '0;
                    n_status   = ST_DONE;
                    case (t_cmd'(i_s_tuser))
                        CMD_INSERT, CMD_ERASE: n_state = S_FIND;
                        CMD_VICTIM: begin
                            if (r_count == '0) begin
                                n_status = ST_ABSENT;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_FIND: begin
                // look for the key, the least recent slot, and the first free slot
                if (r_pend) begin
                    if (hit_now && !r_hit) begin
                        n_hit  = 1'b1;
                        n_slot = r_pidx;
                        n_rank = rd_rank;
                        if (r_cmd == CMD_VICTIM) begin
                            n_vkey = rd_key;
                        end
                    end
                    if (!rd_vld && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free     = r_pidx;
                    end
                end
                if (scan_end) begin
                    n_issue = '0;
                    if (r_hit) begin
                        n_state = S_UPDATE;
                    end else if (r_cmd == CMD_INSERT) begin
                        if (r_count == CAP_C || !r_free_hit) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_slot  = r_free;
                            n_state = S_UPDATE;
                        end
                    end else begin
                        n_status = ST_ABSENT;
                        n_state  = S_DONE;
                    end
                end
            end

            S_UPDATE: begin
                // rewrite ranks one slot per cycle
                if (r_pend) begin
                    if (r_cmd == CMD_INSERT) begin
                        if (is_slot) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {r_key, AW'(0)};
                        end else if (rd_vld && (!r_hit || rd_rank < r_rank)) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_data = {rd_key, AW'(rd_rank + 1'b1)};
                        end
                    end else if (!is_slot && rd_vld && rd_rank > r_rank) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {rd_key, AW'(rd_rank - 1'b1)};
                    end
                end
                if (scan_end) begin
                    if (r_cmd != CMD_INSERT) begin
                        n_valid[r_slot] = 1'b0;
                        n_count         = r_count - 1'b1;
                    end else if (!r_hit) begin
                        n_valid[r_slot] = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // load the result register once it is free
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_vkey   = KEY_PORT_W'(r_vkey);
                    n_out_count  = COUNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= '0;
            r_pend    <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_hit        <= n_hit;
        r_slot       <= n_slot;
        r_rank       <= n_rank;
        r_vkey       <= n_vkey;
        r_free_hit   <= n_free_hit;
        r_free       <= n_free;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_vkey   <= n_out_vkey;
        r_out_count  <= n_out_count;
    end

    // ports
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(OUT_DATA_W - KEY_PORT_W - COUNT_W){1'b0}}, r_out_count, r_out_vkey};

    // count matches the number of valid slots
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("count does not match valid slots");

    // count stays within capacity
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("count above capacity");

    // slot table is only rewritten during the update pass
    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr_en |-> (r_state == S_UPDATE))
        else $error("slot write outside update pass");

    // a full reject only happens with every slot in use
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> (r_count == CAP_C))
        else $error("full status with free slots");

    // sequencer state is one-hot
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

endmodule

// ===== test/tb_lru_replacement_tracker.sv =====
// tb_lru_replacement_tracker: self-checking testbench for the lru replacement tracker
// depends on lrut_pkg and lru_replacement_tracker; a recency queue predicts every result
`timescale 1ns / 100ps

module tb_lru_replacement_tracker
    import lrut_pkg::*;
();

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 32;
    localparam int IDLE_PCT  = 13;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE    = 40;
    localparam logic [KEY_PORT_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_PORT_W) ? '1 : ((KEY_PORT_W'(1) << KEY_BITS) - KEY_PORT_W'(1));

    typedef struct packed {
        t_status               status;
        logic [KEY_PORT_W-1:0] victim;
        logic [COUNT_W-1:0]    count;
    } t_lru_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [KEY_PORT_W-1:0] i_s_tdata  = '0;   // [31:0] key
    logic [1:0]            i_s_tuser  = CMD_NONE;   // [1:0] cmd
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [31:0] victim_key, [36:32] count, rest zero
    logic [1:0]            o_m_tuser;   // [1:0] status

    // predictor state: keys from most recent (front) to least recent (back)
    logic [KEY_PORT_W-1:0] recency_order[$];
    t_lru_result           pending_results[$];
    logic [KEY_PORT_W-1:0] key_pool[32];

    int mismatch_count = 0;
    bit steady         = 1'b0;
    bit hold_token     = 1'b0;
    bit hold_seen      = 1'b0;
    int hold_left      = 0;

    lru_replacement_tracker #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one request to the recency queue and return the result it gives
    function automatic t_lru_result next_lru_result(t_cmd cmd, logic [KEY_PORT_W-1:0] raw_key);
        t_lru_result           res;
        logic [KEY_PORT_W-1:0] key;
        int                    pos;
        key        = raw_key & KEY_MASK;
        res.status = ST_DONE;
        res.victim = '0;
        pos        = -1;
        foreach (recency_order[i])
            if (recency_order[i] == key) pos = i;
        case (cmd)
            CMD_INSERT: begin
                if (pos >= 0) begin
                    recency_order.delete(pos);
                    recency_order.insert(0, key);
                end else if (recency_order.size() >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    recency_order.insert(0, key);
                end
            end
            CMD_VICTIM: begin
                if (recency_order.size() == 0) begin
                    res.status = ST_ABSENT;
                end else begin
                    res.victim = recency_order[$];
                    recency_order.delete(recency_order.size() - 1);
                end
            end
            CMD_ERASE: begin
                if (pos >= 0) recency_order.delete(pos);
                else res.status = ST_ABSENT;
            end
            default: ;
        endcase
        res.count = COUNT_W'(recency_order.size());
        return res;
    endfunction

    // offer one request, with a random gap first unless steady, and record its expected result
    task automatic send_request(input t_cmd cmd, input logic [KEY_PORT_W-1:0] key);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(next_lru_result(cmd, key));
    endtask

    // random traffic over the first span keys of the pool
    task automatic run_random_traffic(input int n, input int span, input int insert_pct);
        int                    pick;
        t_cmd                  cmd;
        logic [KEY_PORT_W-1:0] key;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < insert_pct) cmd = CMD_INSERT;
            else if (pick < insert_pct + 20) cmd = CMD_VICTIM;
            else if (pick < insert_pct + 24) cmd = CMD_NONE;
            else cmd = CMD_ERASE;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(span - 1)];
            else key = $urandom;
            send_request(cmd, key);
        end
    endtask

    // empty set, fill to capacity with walking-bit keys, full reject, touch, victim, erase
    task automatic test_directed_corners();
        send_request(CMD_VICTIM, 32'h0000_0000);
        send_request(CMD_ERASE,  32'h0000_0007);
        send_request(CMD_NONE,   32'h1234_5678);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        for (int i = 0; i < CAPACITY - 2; i++)
            send_request(CMD_INSERT, 32'h1 << i);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_VICTIM, 32'hFFFF_FFFF);
        send_request(CMD_ERASE,  32'h0000_0020);
        send_request(CMD_ERASE,  32'hDEAD_BEEF);
        send_request(CMD_NONE,   32'hFFFF_FFFF);
    endtask

    // mixed commands with idling on both sides
    task automatic test_mixed_traffic();
        run_random_traffic(450, 24, 55);
    endtask

    // back-to-back requests and an always-ready receiver
    task automatic test_no_idle_stream();
        steady = 1'b1;
        run_random_traffic(150, 32, 60);
        steady = 1'b0;
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_result_backpressure();
        hold_token <= ~hold_token;
        run_random_traffic(10, 20, 55);
    endtask

    // few distinct keys: frequent hits, victims and erases near empty
    task automatic test_near_empty_churn();
        run_random_traffic(300, 5, 45);
    endtask

    // insert-heavy: the set stays full and new keys get rejected
    task automatic test_full_churn();
        run_random_traffic(215, 32, 80);
    endtask

    // result ready, with random stalls and an occasional long hold
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic log_mismatch(input string what, input logic [OUT_DATA_W-1:0] want,
                                input logic [OUT_DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch in %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_lru_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("unrequested result", '0, o_m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tuser !== want.status)
                    log_mismatch("status", want.status, o_m_tuser);
                if (o_m_tdata[KEY_PORT_W-1:0] !== want.victim)
                    log_mismatch("victim_key", want.victim, o_m_tdata[KEY_PORT_W-1:0]);
                if (o_m_tdata[KEY_PORT_W+COUNT_W-1:KEY_PORT_W] !== want.count)
                    log_mismatch("count", want.count,
                                 o_m_tdata[KEY_PORT_W+COUNT_W-1:KEY_PORT_W]);
                if (o_m_tdata[OUT_DATA_W-1:KEY_PORT_W+COUNT_W] !== '0)
                    log_mismatch("tdata padding", '0,
                                 o_m_tdata[OUT_DATA_W-1:KEY_PORT_W+COUNT_W]);
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_mixed_traffic();
        test_no_idle_stream();
        test_result_backpressure();
        test_near_empty_churn();
        test_full_churn();
        i_s_tvalid <= 1'b0;

        // drain, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
